[hdl/um32_machine_core_top_assert.svh]
// Assertion macros for the um32 machine core.
// Used by modules that carry concurrent checks; expects clk and arst_n in scope.
`ifndef UM32_MACHINE_CORE_TOP_ASSERT_SVH
`define UM32_MACHINE_CORE_TOP_ASSERT_SVH

// same-cycle implication
`define UM32_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define UM32_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/um32_pkg.sv]
// Shared constants, codes and types of the um32 machine core.
// No dependencies.
package um32_pkg;

	localparam int WORD_W     = 32;
	localparam int HEAP_WORDS = 65536;
	localparam int HEAP_AW    = $clog2(HEAP_WORDS);
	localparam int LEN_W      = HEAP_AW + 1;
	localparam int ARRAY_IDS  = 256;
	localparam int ID_W       = $clog2(ARRAY_IDS);
	localparam int CNT_W      = ID_W + 1;
	localparam int REG_COUNT  = 8;
	localparam int REG_AW     = $clog2(REG_COUNT);

	localparam logic [2:0] FAIL_NONE = 3'd0;
	localparam logic [2:0] FAIL_PC   = 3'd1;
	localparam logic [2:0] FAIL_ID   = 3'd2;
	localparam logic [2:0] FAIL_OFS  = 3'd3;
	localparam logic [2:0] FAIL_DIV  = 3'd4;
	localparam logic [2:0] FAIL_OUT  = 3'd5;
	localparam logic [2:0] FAIL_OP   = 3'd6;
	localparam logic [2:0] FAIL_MEM  = 3'd7;

	localparam logic [3:0] OP_CMOV  = 4'd0;
	localparam logic [3:0] OP_INDEX = 4'd1;
	localparam logic [3:0] OP_AMEND = 4'd2;
	localparam logic [3:0] OP_ADD   = 4'd3;
	localparam logic [3:0] OP_MUL   = 4'd4;
	localparam logic [3:0] OP_DIV   = 4'd5;
	localparam logic [3:0] OP_NAND  = 4'd6;
	localparam logic [3:0] OP_HALT  = 4'd7;
	localparam logic [3:0] OP_ALLOC = 4'd8;
	localparam logic [3:0] OP_FREE  = 4'd9;
	localparam logic [3:0] OP_OUT   = 4'd10;
	localparam logic [3:0] OP_IN    = 4'd11;
	localparam logic [3:0] OP_LOADP = 4'd12;
	localparam logic [3:0] OP_ORTHO = 4'd13;

	localparam logic ITEM_LOAD = 1'b0;

	localparam logic [5:0] A_NONE    = 6'd0;
	localparam logic [5:0] A_ACCEPT  = 6'd1;
	localparam logic [5:0] A_LOAD    = 6'd2;
	localparam logic [5:0] A_START   = 6'd3;
	localparam logic [5:0] A_FETCH   = 6'd4;
	localparam logic [5:0] A_DEC     = 6'd5;
	localparam logic [5:0] A_RDA     = 6'd6;
	localparam logic [5:0] A_RDB     = 6'd7;
	localparam logic [5:0] A_RDC     = 6'd8;
	localparam logic [5:0] A_RDD     = 6'd9;
	localparam logic [5:0] A_FAIL    = 6'd10;
	localparam logic [5:0] A_CMOV    = 6'd11;
	localparam logic [5:0] A_ALU     = 6'd12;
	localparam logic [5:0] A_HALT    = 6'd13;
	localparam logic [5:0] A_IDREAD  = 6'd14;
	localparam logic [5:0] A_MREAD   = 6'd15;
	localparam logic [5:0] A_MLOAD   = 6'd16;
	localparam logic [5:0] A_MSTORE  = 6'd17;
	localparam logic [5:0] A_DIVGO   = 6'd18;
	localparam logic [5:0] A_DIVWR   = 6'd19;
	localparam logic [5:0] A_APOP    = 6'd20;
	localparam logic [5:0] A_APOPCAP = 6'd21;
	localparam logic [5:0] A_ANEW    = 6'd22;
	localparam logic [5:0] A_AMETA   = 6'd23;
	localparam logic [5:0] A_AZERO   = 6'd24;
	localparam logic [5:0] A_AEND    = 6'd25;
	localparam logic [5:0] A_FREE    = 6'd26;
	localparam logic [5:0] A_OUT     = 6'd27;
	localparam logic [5:0] A_IN      = 6'd28;
	localparam logic [5:0] A_JUMP    = 6'd29;
	localparam logic [5:0] A_CINIT   = 6'd30;
	localparam logic [5:0] A_CRD     = 6'd31;
	localparam logic [5:0] A_CWR     = 6'd32;
	localparam logic [5:0] A_CEND    = 6'd33;
	localparam logic [5:0] A_ORTHO   = 6'd34;
	localparam logic [5:0] A_FIN     = 6'd35;

	typedef struct packed {
		logic        opcode;
		logic [31:0] program_word;
		logic [7:0]  console_byte;
		logic        console_eof;
	} item_t;

	typedef struct packed {
		logic        out_valid;
		logic [7:0]  out_byte;
		logic        input_used;
		logic        halted;
		logic [2:0]  fail_code;
		logic [31:0] program_counter;
	} result_t;

	typedef struct packed {
		logic [5:0] act;
		logic [2:0] fail;
	} cmd_t;

	typedef struct packed {
		logic [3:0] op;
		logic       item_load;
		logic       started;
		logic       blocked;
		logic       heap_full;
		logic       pc_ok;
		logic       rc_zero;
		logic       rc_big;
		logic       fits_rc;
		logic       fits_len;
		logic       free_nz;
		logic       next_avail;
		logic       id_zero;
		logic       id_ok;
		logic       ofs_ok;
		logic       cnt_done;
		logic       div_done;
		logic       out_free;
	} status_t;

endpackage

[hdl/um32_machine_core_top.sv]
// Top level of the um32 machine core: controller plus datapath.
// Depends on um32_pkg, um32_ctrl, um32_dpath.
//
// Input channel item/item_valid/item_stall: a load beat (opcode 0) appends a
// program word to array 0 before the first run beat; a run beat (opcode 1)
// executes one instruction and may take console_byte or console_eof.
// Output channel result/result_valid/result_stall: one result beat per item.
// A load item passes dispatch and result; a run item passes dispatch,
// heap fetch, decode, three register file reads, execute and result.
// Index adds a check step and a load step, amend and free add a check step,
// divide waits for the bit-serial divider, allocation adds id and metadata
// steps and zeroes each new word in turn, and load-program adds a check step
// plus, for a non-zero id, a copy pass that reads and writes each word.
// One item is in flight at a time; item_stall is low only while idle.
// A finished result waits in an output register; the next item can be taken
// meanwhile, and its own result waits until the receiver drops result_stall.
// Reset clears registers, pc, flags and the id allocator at once; no
// clearing pass is run, heap words are only read after being written.
module um32_machine_core_top import um32_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	cmd_t    cmd;
	status_t st;

	um32_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .item_valid(item_valid),
		.item_stall(item_stall), .st(st), .cmd(cmd)
	);

	um32_dpath u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .item(item),
		.result_stall(result_stall), .st(st),
		.result_valid(result_valid), .result(result)
	);

endmodule

[hdl/um32_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module um32_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hdl/um32_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on um32_pkg.
module um32_div import um32_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WORD_W-1:0] dividend,
	input  logic [WORD_W-1:0] divisor,
	output logic              done,
	output logic [WORD_W-1:0] quotient
);

	localparam int DCW = $clog2(WORD_W) + 1;

	logic           busy_q;
	logic [DCW-1:0] cnt_q;
	logic [WORD_W-1:0] rem_q, quo_q, dv_q;
	logic [WORD_W:0]   trial;

	assign trial    = {rem_q, quo_q[WORD_W-1]} - {1'b0, dv_q};
	assign done     = busy_q && (cnt_q == '0);
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DCW'(WORD_W);
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end else begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dv_q  <= divisor;
		end else if (busy_q && (cnt_q != '0)) begin
			if (trial[WORD_W]) begin
				rem_q <= {rem_q[WORD_W-2:0], quo_q[WORD_W-1]};
			end else begin
				rem_q <= trial[WORD_W-1:0];
			end
			quo_q <= {quo_q[WORD_W-2:0], ~trial[WORD_W]};
		end
	end

endmodule

[hdl/um32_dpath.sv]
// Datapath: registers, heap and array tables, divider and result register.
// Depends on um32_pkg, um32_ram, um32_div.
module um32_dpath import um32_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    cmd,
	input  item_t   item,
	input  logic    result_stall,
	output status_t st,
	output logic    result_valid,
	output result_t result
);

	item_t item_q;
	logic [WORD_W-1:0] pc_q, ir_q, ra_q, rb_q, rc_q, id_q, off_q;
	logic started_q, halted_q, outv_q, used_q, res_valid_q, rf_rdvld_q;
	logic [2:0] fail_q;
	logic [7:0] outb_q;
	logic [LEN_W-1:0] base0_q, len0_q, top_q, cnt_q, n_q;
	logic [CNT_W-1:0] next_q, free_q;
	logic [ID_W-1:0] aid_q;
	logic [HEAP_AW-1:0] src_q;
	logic [REG_COUNT-1:0] rf_vld_q;
	result_t res_q;

	logic [3:0] op;
	logic [REG_AW-1:0] fa, fb, fc, fo;
	logic [5:0] act;

	logic rf_we, rf_re;
	logic [REG_AW-1:0] rf_waddr, rf_raddr;
	logic [WORD_W-1:0] rf_wdata, rf_rdata, rf_rd;

	logic h_we, h_re;
	logic [HEAP_AW-1:0] h_waddr, h_raddr;
	logic [WORD_W-1:0] h_wdata, h_rdata;

	logic [HEAP_AW-1:0] base_rdata, base_cur, acc_addr, dst_addr, src_addr, fetch_addr;
	logic [LEN_W-1:0] len_rdata, len_cur;
	logic [LEN_W:0] fetch_sum, fit_rc_sum, fit_len_sum;
	logic [ID_W-1:0] stk_rdata;
	logic [WORD_W-1:0] id_sel, alu_res, div_q;
	logic [2*WORD_W-1:0] prod;
	logic div_done;

	logic act_we, act_wdata, act_rdata;
	logic [ID_W-1:0] act_waddr;

	assign act = cmd.act;
	assign op  = ir_q[31:28];
	assign fa  = ir_q[8:6];
	assign fb  = ir_q[5:3];
	assign fc  = ir_q[2:0];
	assign fo  = ir_q[27:25];

	// register file
	always_comb begin
		case (act)
			A_RDA:   rf_raddr = fa;
			A_RDB:   rf_raddr = fb;
			default: rf_raddr = fc;
		endcase
	end
	assign rf_re = (act == A_RDA) || (act == A_RDB) || (act == A_RDC);
	assign rf_rd = rf_rdvld_q ? rf_rdata : '0;

	assign prod = rb_q * rc_q;
	always_comb begin
		case (op)
			OP_ADD:  alu_res = rb_q + rc_q;
			OP_MUL:  alu_res = prod[WORD_W-1:0];
			default: alu_res = ~(rb_q & rc_q);
		endcase
	end

	always_comb begin
		rf_we    = 1'b0;
		rf_waddr = fa;
		rf_wdata = rb_q;
		case (act)
			A_CMOV:  rf_we = (rc_q != '0);
			A_ALU: begin
				rf_we    = 1'b1;
				rf_wdata = alu_res;
			end
			A_MLOAD: begin
				rf_we    = 1'b1;
				rf_wdata = h_rdata;
			end
			A_DIVWR: begin
				rf_we    = 1'b1;
				rf_wdata = div_q;
			end
			A_AMETA: begin
				rf_we    = 1'b1;
				rf_waddr = fb;
				rf_wdata = WORD_W'(aid_q);
			end
			A_IN: begin
				rf_we    = 1'b1;
				rf_waddr = fc;
				rf_wdata = item_q.console_eof ? '1 : WORD_W'(item_q.console_byte);
			end
			A_ORTHO: begin
				rf_we    = 1'b1;
				rf_waddr = fo;
				rf_wdata = WORD_W'(ir_q[24:0]);
			end
			default: rf_we = 1'b0;
		endcase
	end

	um32_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_rf (
		.clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
		.re(rf_re), .raddr(rf_raddr), .rdata(rf_rdata)
	);

	// array table and heap addressing
	assign len_cur  = (id_q == '0) ? len0_q : len_rdata;
	assign base_cur = (id_q == '0) ? base0_q[HEAP_AW-1:0] : base_rdata;
	assign acc_addr = base_cur + off_q[HEAP_AW-1:0];
	assign dst_addr = top_q[HEAP_AW-1:0] + cnt_q[HEAP_AW-1:0];
	assign src_addr = src_q + cnt_q[HEAP_AW-1:0];
	assign fetch_sum  = {1'b0, base0_q} + {1'b0, pc_q[LEN_W-1:0]};
	assign fetch_addr = fetch_sum[HEAP_AW-1:0];
	assign fit_rc_sum  = {1'b0, rc_q[LEN_W-1:0]} + {1'b0, top_q};
	assign fit_len_sum = {1'b0, len_cur} + {1'b0, top_q};

	always_comb begin
		case (op)
			OP_AMEND: id_sel = ra_q;
			OP_FREE:  id_sel = rc_q;
			default:  id_sel = rb_q;
		endcase
	end

	always_comb begin
		case (act)
			A_FETCH: h_raddr = fetch_addr;
			A_MREAD: h_raddr = acc_addr;
			default: h_raddr = src_addr;
		endcase
	end
	assign h_re = (act == A_FETCH) || (act == A_MREAD) || (act == A_CRD);

	always_comb begin
		h_we    = 1'b1;
		h_waddr = dst_addr;
		h_wdata = '0;
		case (act)
			A_LOAD: begin
				h_waddr = top_q[HEAP_AW-1:0];
				h_wdata = item_q.program_word;
			end
			A_MSTORE: begin
				h_waddr = acc_addr;
				h_wdata = rc_q;
			end
			A_AZERO: h_wdata = '0;
			A_CWR:   h_wdata = h_rdata;
			default: h_we = 1'b0;
		endcase
	end

	um32_ram #(.WIDTH(WORD_W), .DEPTH(HEAP_WORDS)) u_heap (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.re(h_re), .raddr(h_raddr), .rdata(h_rdata)
	);

	um32_ram #(.WIDTH(HEAP_AW), .DEPTH(ARRAY_IDS)) u_base (
		.clk(clk), .we(act == A_AMETA), .waddr(aid_q), .wdata(top_q[HEAP_AW-1:0]),
		.re(act == A_IDREAD), .raddr(id_sel[ID_W-1:0]), .rdata(base_rdata)
	);

	um32_ram #(.WIDTH(LEN_W), .DEPTH(ARRAY_IDS)) u_len (
		.clk(clk), .we(act == A_AMETA), .waddr(aid_q), .wdata(rc_q[LEN_W-1:0]),
		.re(act == A_IDREAD), .raddr(id_sel[ID_W-1:0]), .rdata(len_rdata)
	);

	// active flags; ids below next_q are written at allocation, id 0 is always active
	assign act_we    = (act == A_AMETA) || (act == A_FREE);
	assign act_waddr = (act == A_AMETA) ? aid_q : id_q[ID_W-1:0];
	assign act_wdata = (act == A_AMETA);

	um32_ram #(.WIDTH(1), .DEPTH(ARRAY_IDS)) u_act (
		.clk(clk), .we(act_we), .waddr(act_waddr), .wdata(act_wdata),
		.re(act == A_IDREAD), .raddr(id_sel[ID_W-1:0]), .rdata(act_rdata)
	);

	um32_ram #(.WIDTH(ID_W), .DEPTH(ARRAY_IDS)) u_stack (
		.clk(clk), .we((act == A_FREE) && (free_q < CNT_W'(ARRAY_IDS))),
		.waddr(free_q[ID_W-1:0]), .wdata(id_q[ID_W-1:0]),
		.re(act == A_APOP), .raddr(ID_W'(free_q - 1'b1)), .rdata(stk_rdata)
	);

	um32_div u_div (
		.clk(clk), .arst_n(arst_n), .start(act == A_DIVGO),
		.dividend(rb_q), .divisor(rc_q), .done(div_done), .quotient(div_q)
	);

	// status
	always_comb begin
		st.op         = op;
		st.item_load  = (item_q.opcode == ITEM_LOAD);
		st.started    = started_q;
		st.blocked    = halted_q || (fail_q != FAIL_NONE);
		st.heap_full  = (top_q >= LEN_W'(HEAP_WORDS));
		st.pc_ok      = (pc_q < WORD_W'(len0_q)) && (fetch_sum < (LEN_W+1)'(HEAP_WORDS));
		st.rc_zero    = (rc_q == '0);
		st.rc_big     = (rc_q > WORD_W'(255));
		st.fits_rc    = (rc_q[WORD_W-1:LEN_W] == '0) && (fit_rc_sum <= (LEN_W+1)'(HEAP_WORDS));
		st.fits_len   = (fit_len_sum <= (LEN_W+1)'(HEAP_WORDS));
		st.free_nz    = (free_q != '0);
		st.next_avail = (next_q < CNT_W'(ARRAY_IDS));
		st.id_zero    = (id_q == '0);
		st.id_ok      = (id_q < WORD_W'(next_q)) && ((id_q == '0) || act_rdata);
		st.ofs_ok     = (off_q < WORD_W'(len_cur));
		st.cnt_done   = (cnt_q == n_q);
		st.div_done   = div_done;
		st.out_free   = !res_valid_q || !result_stall;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= '0;
			started_q   <= 1'b0;
			halted_q    <= 1'b0;
			fail_q      <= FAIL_NONE;
			outv_q      <= 1'b0;
			used_q      <= 1'b0;
			base0_q     <= '0;
			len0_q      <= '0;
			top_q       <= '0;
			next_q      <= CNT_W'(1);
			free_q      <= '0;
			rf_vld_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (rf_we) begin
				rf_vld_q[rf_waddr] <= 1'b1;
			end
			if (act == A_FIN) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
			case (act)
				A_ACCEPT: begin
					outv_q <= 1'b0;
					used_q <= 1'b0;
				end
				A_LOAD: begin
					top_q  <= top_q + 1'b1;
					len0_q <= len0_q + 1'b1;
				end
				A_START: started_q <= 1'b1;
				A_FAIL:  fail_q <= cmd.fail;
				A_HALT:  halted_q <= 1'b1;
				A_CMOV, A_ALU, A_MLOAD, A_MSTORE, A_DIVWR, A_ORTHO: pc_q <= pc_q + 1'b1;
				A_APOPCAP: free_q <= free_q - 1'b1;
				A_ANEW:    next_q <= next_q + 1'b1;
				A_AEND: begin
					top_q <= top_q + rc_q[LEN_W-1:0];
					pc_q  <= pc_q + 1'b1;
				end
				A_FREE: begin
					if (free_q < CNT_W'(ARRAY_IDS)) begin
						free_q <= free_q + 1'b1;
					end
					pc_q <= pc_q + 1'b1;
				end
				A_OUT: begin
					outv_q <= 1'b1;
					pc_q   <= pc_q + 1'b1;
				end
				A_IN: begin
					used_q <= 1'b1;
					pc_q   <= pc_q + 1'b1;
				end
				A_JUMP: pc_q <= rc_q;
				A_CEND: begin
					base0_q <= top_q;
					len0_q  <= n_q;
					top_q   <= top_q + n_q;
					pc_q    <= rc_q;
				end
				default: pc_q <= pc_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rf_re) begin
			rf_rdvld_q <= rf_vld_q[rf_raddr];
		end
		case (act)
			A_ACCEPT: item_q <= item;
			A_DEC:    ir_q <= h_rdata;
			A_RDB:    ra_q <= rf_rd;
			A_RDC:    rb_q <= rf_rd;
			A_RDD:    rc_q <= rf_rd;
			A_IDREAD: begin
				id_q  <= id_sel;
				off_q <= (op == OP_INDEX) ? rc_q : rb_q;
			end
			A_APOPCAP: aid_q <= stk_rdata;
			A_ANEW:    aid_q <= next_q[ID_W-1:0];
			A_AMETA: begin
				cnt_q <= '0;
				n_q   <= rc_q[LEN_W-1:0];
			end
			A_AZERO, A_CWR: cnt_q <= cnt_q + 1'b1;
			A_CINIT: begin
				cnt_q <= '0;
				n_q   <= len_cur;
				src_q <= base_cur;
			end
			A_OUT: outb_q <= rc_q[7:0];
			A_FIN: begin
				res_q.out_valid       <= outv_q;
				res_q.out_byte        <= outv_q ? outb_q : 8'd0;
				res_q.input_used      <= used_q;
				res_q.halted          <= halted_q;
				res_q.fail_code       <= fail_q;
				res_q.program_counter <= pc_q;
			end
			default: cnt_q <= cnt_q;
		endcase
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

[hdl/um32_ctrl.sv]
// Controller state machine: sequences fetch, operand reads and execution.
// Depends on um32_pkg and um32_machine_core_top_assert.svh.
`include "um32_machine_core_top_assert.svh"
module um32_ctrl import um32_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  status_t st,
	output cmd_t    cmd
);

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_DISP  = 5'd1;
	localparam logic [4:0] S_FETCH = 5'd2;
	localparam logic [4:0] S_DEC   = 5'd3;
	localparam logic [4:0] S_RDA   = 5'd4;
	localparam logic [4:0] S_RDB   = 5'd5;
	localparam logic [4:0] S_RDC   = 5'd6;
	localparam logic [4:0] S_RDD   = 5'd7;
	localparam logic [4:0] S_EXE   = 5'd8;
	localparam logic [4:0] S_META  = 5'd9;
	localparam logic [4:0] S_MLD   = 5'd10;
	localparam logic [4:0] S_DIV   = 5'd11;
	localparam logic [4:0] S_APOP  = 5'd12;
	localparam logic [4:0] S_AMETA = 5'd13;
	localparam logic [4:0] S_AZERO = 5'd14;
	localparam logic [4:0] S_CLOOP = 5'd15;
	localparam logic [4:0] S_CWR   = 5'd16;
	localparam logic [4:0] S_FIN   = 5'd17;

	logic [4:0] state_q, state_d;

	always_comb begin
		state_d    = state_q;
		cmd.act    = A_NONE;
		cmd.fail   = FAIL_NONE;
		item_stall = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.act = A_ACCEPT;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				if (st.item_load) begin
					state_d = S_FIN;
					if (st.started || st.blocked) begin
						cmd.act = A_NONE;
					end else if (st.heap_full) begin
						cmd.act  = A_FAIL;
						cmd.fail = FAIL_MEM;
					end else begin
						cmd.act = A_LOAD;
					end
				end else begin
					cmd.act = A_START;
					state_d = st.blocked ? S_FIN : S_FETCH;
				end
			end
			S_FETCH: begin
				if (!st.pc_ok) begin
					cmd.act  = A_FAIL;
					cmd.fail = FAIL_PC;
					state_d  = S_FIN;
				end else begin
					cmd.act = A_FETCH;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				cmd.act = A_DEC;
				state_d = S_RDA;
			end
			S_RDA: begin
				cmd.act = A_RDA;
				state_d = S_RDB;
			end
			S_RDB: begin
				cmd.act = A_RDB;
				state_d = S_RDC;
			end
			S_RDC: begin
				cmd.act = A_RDC;
				state_d = S_RDD;
			end
			S_RDD: begin
				cmd.act = A_RDD;
				state_d = S_EXE;
			end
			S_EXE: begin
				state_d = S_FIN;
				case (st.op)
					OP_CMOV: cmd.act = A_CMOV;
					OP_ADD, OP_MUL, OP_NAND: cmd.act = A_ALU;
					OP_INDEX, OP_AMEND, OP_FREE, OP_LOADP: begin
						cmd.act = A_IDREAD;
						state_d = S_META;
					end
					OP_DIV: begin
						if (st.rc_zero) begin
							cmd.act  = A_FAIL;
							cmd.fail = FAIL_DIV;
						end else begin
							cmd.act = A_DIVGO;
							state_d = S_DIV;
						end
					end
					OP_HALT: cmd.act = A_HALT;
					OP_ALLOC: begin
						if (!st.fits_rc) begin
							cmd.act  = A_FAIL;
							cmd.fail = FAIL_MEM;
						end else if (st.free_nz) begin
							cmd.act = A_APOP;
							state_d = S_APOP;
						end else if (st.next_avail) begin
							cmd.act = A_ANEW;
							state_d = S_AMETA;
						end else begin
							cmd.act  = A_FAIL;
							cmd.fail = FAIL_MEM;
						end
					end
					OP_OUT: begin
						if (st.rc_big) begin
							cmd.act  = A_FAIL;
							cmd.fail = FAIL_OUT;
						end else begin
							cmd.act = A_OUT;
						end
					end
					OP_IN:    cmd.act = A_IN;
					OP_ORTHO: cmd.act = A_ORTHO;
					default: begin
						cmd.act  = A_FAIL;
						cmd.fail = FAIL_OP;
					end
				endcase
			end
			S_META: begin
				state_d = S_FIN;
				case (st.op)
					OP_INDEX, OP_AMEND: begin
						if (!st.id_ok) begin
							cmd.act  = A_FAIL;
							cmd.fail = FAIL_ID;
						end else if (!st.ofs_ok) begin
							cmd.act  = A_FAIL;
							cmd.fail = FAIL_OFS;
						end else if (st.op == OP_INDEX) begin
							cmd.act = A_MREAD;
							state_d = S_MLD;
						end else begin
							cmd.act = A_MSTORE;
						end
					end
					OP_FREE: begin
						if (st.id_zero || !st.id_ok) begin
							cmd.act  = A_FAIL;
							cmd.fail = FAIL_ID;
						end else begin
							cmd.act = A_FREE;
						end
					end
					default: begin
						if (st.id_zero) begin
							cmd.act = A_JUMP;
						end else if (!st.id_ok) begin
							cmd.act  = A_FAIL;
							cmd.fail = FAIL_ID;
						end else if (!st.fits_len) begin
							cmd.act  = A_FAIL;
							cmd.fail = FAIL_MEM;
						end else begin
							cmd.act = A_CINIT;
							state_d = S_CLOOP;
						end
					end
				endcase
			end
			S_MLD: begin
				cmd.act = A_MLOAD;
				state_d = S_FIN;
			end
			S_DIV: begin
				if (st.div_done) begin
					cmd.act = A_DIVWR;
					state_d = S_FIN;
				end
			end
			S_APOP: begin
				cmd.act = A_APOPCAP;
				state_d = S_AMETA;
			end
			S_AMETA: begin
				cmd.act = A_AMETA;
				state_d = S_AZERO;
			end
			S_AZERO: begin
				if (st.cnt_done) begin
					cmd.act = A_AEND;
					state_d = S_FIN;
				end else begin
					cmd.act = A_AZERO;
				end
			end
			S_CLOOP: begin
				if (st.cnt_done) begin
					cmd.act = A_CEND;
					state_d = S_FIN;
				end else begin
					cmd.act = A_CRD;
					state_d = S_CWR;
				end
			end
			S_CWR: begin
				cmd.act = A_CWR;
				state_d = S_CLOOP;
			end
			S_FIN: begin
				if (st.out_free) begin
					cmd.act = A_FIN;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`UM32_ASSERT_NEXT(a_accept_disp, item_valid && !item_stall, state_q == S_DISP, "accepted beat not dispatched")
	`UM32_ASSERT_NEXT(a_fin_hold, (state_q == S_FIN) && !st.out_free, state_q == S_FIN, "result dropped while stalled")
	`UM32_ASSERT_NOW(a_div_op, state_q == S_DIV, st.op == OP_DIV, "divider wait without divide")
	`UM32_ASSERT_NEXT(a_div_start, (state_q == S_EXE) && (st.op == OP_DIV) && !st.rc_zero, state_q == S_DIV, "divide not started")

endmodule

[tb/tb_top.sv]
// Self-checking testbench for um32_machine_core_top: loads a looping program
// of random safe instructions, runs it and checks every result beat.
// Depends on um32_pkg and the um32 machine core RTL.
module tb_top import um32_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RUN_ITEMS   = 1650;
	localparam int CYCLE_LIMIT = 2000000;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	um32_machine_core_top dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result)
	);

	always #5 clk = ~clk;

	// machine state mirror
	logic [31:0] regs [REG_COUNT];
	logic [31:0] pc;
	logic        started, halted;
	logic [2:0]  fail;
	logic [31:0] arr_base [ARRAY_IDS];
	logic [31:0] arr_len [ARRAY_IDS];
	logic        arr_act [ARRAY_IDS];
	logic [31:0] stack_ids [ARRAY_IDS];
	int unsigned free_cnt, next_id, heap_top;
	logic [31:0] heap [HEAP_WORDS];
	result_t     step_res;

	item_t       pending [$];
	result_t     expected [$];
	logic [31:0] prog_words [$];
	int          total_items, sent, accepted, errors, cycles;
	logic        took;

	function automatic logic id_good(logic [31:0] id);
		return id < next_id && id < ARRAY_IDS && arr_act[id];
	endfunction

	function automatic logic heap_fits(logic [31:0] n);
		return longint'(n) <= longint'(HEAP_WORDS) - longint'(heap_top);
	endfunction

	function automatic logic [2:0] exec_instr(item_t it);
		logic [31:0] w, id, off, n;
		logic [3:0]  op;
		logic [2:0]  a, b, c;
		if (pc >= arr_len[0] || arr_base[0] + pc >= HEAP_WORDS)
			return FAIL_PC;
		w = heap[arr_base[0] + pc];
		op = w[31:28];
		a = w[8:6];
		b = w[5:3];
		c = w[2:0];
		case (op)
			OP_CMOV: if (regs[c] != 0) regs[a] = regs[b];
			OP_INDEX: begin
				id = regs[b];
				off = regs[c];
				if (!id_good(id)) return FAIL_ID;
				if (off >= arr_len[id]) return FAIL_OFS;
				regs[a] = heap[(arr_base[id] + off) % HEAP_WORDS];
			end
			OP_AMEND: begin
				id = regs[a];
				off = regs[b];
				if (!id_good(id)) return FAIL_ID;
				if (off >= arr_len[id]) return FAIL_OFS;
				heap[(arr_base[id] + off) % HEAP_WORDS] = regs[c];
			end
			OP_ADD: regs[a] = regs[b] + regs[c];
			OP_MUL: regs[a] = regs[b] * regs[c];
			OP_DIV: begin
				if (regs[c] == 0) return FAIL_DIV;
				regs[a] = regs[b] / regs[c];
			end
			OP_NAND: regs[a] = ~(regs[b] & regs[c]);
			OP_HALT: begin
				halted = 1'b1;
				return FAIL_NONE;
			end
			OP_ALLOC: begin
				n = regs[c];
				if (!heap_fits(n)) return FAIL_MEM;
				if (free_cnt > 0) begin
					id = stack_ids[(free_cnt - 1) % ARRAY_IDS];
					free_cnt--;
				end else if (next_id < ARRAY_IDS) begin
					id = next_id;
					next_id++;
				end else
					return FAIL_MEM;
				id = id % ARRAY_IDS;
				arr_base[id] = heap_top;
				arr_len[id] = n;
				arr_act[id] = 1'b1;
				for (int unsigned i = 0; i < n; i++)
					heap[(heap_top + i) % HEAP_WORDS] = '0;
				heap_top += n;
				regs[b] = id;
			end
			OP_FREE: begin
				id = regs[c];
				if (id == 0 || !id_good(id)) return FAIL_ID;
				arr_act[id] = 1'b0;
				arr_len[id] = 0;
				if (free_cnt < ARRAY_IDS) begin
					stack_ids[free_cnt] = id;
					free_cnt++;
				end
			end
			OP_OUT: begin
				if (regs[c] > 255) return FAIL_OUT;
				step_res.out_valid = 1'b1;
				step_res.out_byte = regs[c][7:0];
			end
			OP_IN: begin
				step_res.input_used = 1'b1;
				regs[c] = it.console_eof ? 32'hFFFF_FFFF : {24'd0, it.console_byte};
			end
			OP_LOADP: begin
				id = regs[b];
				if (id != 0) begin
					if (!id_good(id)) return FAIL_ID;
					n = arr_len[id];
					if (!heap_fits(n)) return FAIL_MEM;
					for (int unsigned i = 0; i < n; i++)
						heap[(heap_top + i) % HEAP_WORDS] =
							heap[(arr_base[id] + i) % HEAP_WORDS];
					arr_base[0] = heap_top;
					arr_len[0] = n;
					heap_top += n;
				end
				pc = regs[c];
				return FAIL_NONE;
			end
			OP_ORTHO: regs[w[27:25]] = {7'd0, w[24:0]};
			default: return FAIL_OP;
		endcase
		pc++;
		return FAIL_NONE;
	endfunction

	function automatic result_t machine_step(item_t it);
		logic [2:0] code;
		step_res = '0;
		if (it.opcode == ITEM_LOAD) begin
			if (!started && !halted && fail == FAIL_NONE) begin
				if (heap_top < HEAP_WORDS) begin
					heap[heap_top] = it.program_word;
					heap_top++;
					arr_len[0]++;
				end else
					fail = FAIL_MEM;
			end
		end else begin
			started = 1'b1;
			if (!halted && fail == FAIL_NONE) begin
				code = exec_instr(it);
				if (code != FAIL_NONE) begin
					fail = code;
					step_res = '0;
				end
			end
		end
		step_res.halted = halted;
		step_res.fail_code = fail;
		step_res.program_counter = pc;
		return step_res;
	endfunction

	function automatic logic [31:0] instr(logic [3:0] op, logic [2:0] a, logic [2:0] b,
			logic [2:0] c);
		return {op, 19'($urandom), a, b, c};
	endfunction

	function automatic logic [31:0] ortho(logic [2:0] r, logic [24:0] v);
		return {OP_ORTHO, r, v};
	endfunction

	function automatic logic [2:0] wreg();
		return 3'($urandom_range(1, 6));
	endfunction

	// r0 stays zero and r7 holds the loop target
	task automatic add_block(int kind);
		logic [3:0] alu_ops [4];
		int n;
		alu_ops = '{OP_ADD, OP_MUL, OP_NAND, OP_CMOV};
		case (kind)
			0: prog_words.push_back(ortho(wreg(), 25'($urandom)));
			1: prog_words.push_back(instr(alu_ops[$urandom_range(0, 3)], wreg(),
				3'($urandom), 3'($urandom)));
			2: begin
				prog_words.push_back(ortho(3'd6, $urandom_range(0, 1) ?
					25'($urandom_range(1, 15)) : (25'($urandom) | 25'd1)));
				prog_words.push_back(instr(OP_DIV, 3'($urandom_range(1, 5)), 3'($urandom),
					3'd6));
			end
			3: begin
				prog_words.push_back(ortho(3'd6, 25'($urandom_range(0, 255))));
				prog_words.push_back(instr(OP_OUT, 3'($urandom), 3'($urandom), 3'd6));
			end
			4: prog_words.push_back(instr(OP_IN, 3'($urandom), 3'($urandom), wreg()));
			default: begin
				n = $urandom_range(0, 4);
				prog_words.push_back(ortho(3'd6, 25'(n)));
				prog_words.push_back(instr(OP_ALLOC, 3'($urandom), 3'd4, 3'd6));
				if (n > 0) begin
					prog_words.push_back(ortho(3'd3, 25'($urandom_range(0, n - 1))));
					prog_words.push_back(instr(OP_AMEND, 3'd4, 3'd3, 3'($urandom)));
					prog_words.push_back(instr(OP_INDEX, 3'($urandom_range(1, 2)), 3'd4,
						3'd3));
				end
				prog_words.push_back(instr(OP_FREE, 3'($urandom), 3'($urandom), 3'd4));
			end
		endcase
	endtask

	task automatic queue_item(item_t it);
		pending.push_back(it);
		expected.push_back(machine_step(it));
	endtask

	task automatic report(string msg);
		$display("error @%0t: %s", $realtime, msg);
		errors++;
	endtask

	initial begin
		item_t it;
		for (int i = 0; i < REG_COUNT; i++) regs[i] = '0;
		for (int i = 0; i < ARRAY_IDS; i++) begin
			arr_base[i] = '0;
			arr_len[i] = '0;
			arr_act[i] = 1'b0;
			stack_ids[i] = '0;
		end
		arr_act[0] = 1'b1;
		pc = '0;
		started = 1'b0;
		halted = 1'b0;
		fail = FAIL_NONE;
		free_cnt = 0;
		next_id = 1;
		heap_top = 0;
		// opening blocks use each block kind once
		for (int k = 0; k < 6; k++) add_block(k);
		prog_words.push_back(ortho(3'd5, 25'h1FF_FFFF));
		prog_words.push_back(instr(OP_MUL, 3'd5, 3'd5, 3'd5));
		prog_words.push_back(instr(OP_NAND, 3'd1, 3'd0, 3'd0));
		while (prog_words.size() < 200) add_block($urandom_range(0, 7));
		prog_words.push_back(instr(OP_LOADP, 3'($urandom), 3'd0, 3'd7));
		foreach (prog_words[i]) begin
			it = '0;
			it.opcode = ITEM_LOAD;
			it.program_word = prog_words[i];
			it.console_byte = 8'($urandom);
			it.console_eof = 1'($urandom);
			queue_item(it);
		end
		for (int i = 0; i < RUN_ITEMS; i++) begin
			it.opcode = ~ITEM_LOAD;
			it.program_word = $urandom;
			it.console_byte = 8'($urandom);
			it.console_eof = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 49) == 0) begin
				it.opcode = ITEM_LOAD;
				i--;
			end
			queue_item(it);
		end
		total_items = pending.size();
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		wait (accepted == total_items && expected.size() == 0);
		repeat (30) @(posedge clk);
		if (errors == 0)
			$display("um32_machine_core_top: match");
		else
			$display("um32_machine_core_top: mismatch");
		$finish;
	end

	function automatic int idle_pct(logic rx);
		int ph;
		ph = total_items ? sent * 3 / total_items : 0;
		if (ph == 0) return rx ? 64 : 33;
		if (ph == 1) return rx ? 33 : 64;
		return 0;
	endfunction

	always @(negedge clk) begin
		if (arst_n) begin
			result_stall <= ($urandom_range(0, 99) < idle_pct(1'b1));
			if (!item_valid || took) begin
				if (pending.size() > 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
					item <= pending.pop_front();
					item_valid <= 1'b1;
					sent++;
				end else
					item_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("um32_machine_core_top: mismatch");
			$finish;
		end
		took <= arst_n && item_valid && !item_stall;
		if (arst_n && item_valid && !item_stall) accepted++;
		if (arst_n && result_valid && !result_stall) begin
			if (expected.size() == 0)
				report("result beat with nothing expected");
			else begin
				want = expected.pop_front();
				if (result.out_valid !== want.out_valid)
					report($sformatf("out_valid %b want %b", result.out_valid,
						want.out_valid));
				if (result.out_byte !== want.out_byte)
					report($sformatf("out_byte %h want %h", result.out_byte, want.out_byte));
				if (result.input_used !== want.input_used)
					report($sformatf("input_used %b want %b", result.input_used,
						want.input_used));
				if (result.halted !== want.halted)
					report($sformatf("halted %b want %b", result.halted, want.halted));
				if (result.fail_code !== want.fail_code)
					report($sformatf("fail_code %0d want %0d", result.fail_code,
						want.fail_code));
				if (result.program_counter !== want.program_counter)
					report($sformatf("pc %h want %h", result.program_counter,
						want.program_counter));
			end
		end
	end

endmodule

[filelist.f]
+incdir+hdl
hdl/um32_pkg.sv
hdl/um32_ram.sv
hdl/um32_div.sv
hdl/um32_dpath.sv
hdl/um32_ctrl.sv
hdl/um32_machine_core_top.sv
tb/tb_top.sv
